// File: design/phe_pkg.sv
`default_nettype none
package phe_pkg;

  // Default table geometry
  localparam int DEF_NUM_HASH_FUNCS = 16;
  localparam int DEF_MAX_DEGREE     = 4;

  // Field widths
  localparam int HASH_W  = 4;
  localparam int TERM_W  = 3;
  localparam int COEFF_W = 63;
  localparam int KEY_W   = 63;
  localparam int KB_W    = 6;
  localparam int RANGE_W = 63;
  localparam int DEG_W   = 3;

  // Multiplier slice and remainder unit widths
  localparam int MUL_W  = 32;
  localparam int DIVD_W = 64;

  // Configuration port
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    REG_KEY_BITS    = 2'd0,
    REG_HASH_RANGE  = 2'd1,
    REG_POLY_DEGREE = 2'd2
  } reg_idx_t;

  localparam logic [KB_W-1:0]    KEY_BITS_RST    = KB_W'(32);
  localparam logic [RANGE_W-1:0] HASH_RANGE_RST  = RANGE_W'(65536);
  localparam logic [DEG_W-1:0]   POLY_DEGREE_RST = DEG_W'(1);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_LOG   = 12'b0000_0000_0010,
    S_RD    = 12'b0000_0000_0100,
    S_ADD   = 12'b0000_0000_1000,
    S_M0    = 12'b0000_0001_0000,
    S_M1    = 12'b0000_0010_0000,
    S_M2    = 12'b0000_0100_0000,
    S_M3    = 12'b0000_1000_0000,
    S_SHIFT = 12'b0001_0000_0000,
    S_ADDC  = 12'b0010_0000_0000,
    S_MOD   = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIVD_W-1:0]  dividend;
    logic [RANGE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [RANGE_W-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

// File: design/phe_if.sv
`default_nettype none
interface phe_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [phe_pkg::HASH_W-1:0]     hash_index;
  logic [phe_pkg::TERM_W-1:0]     term_index;
  logic [phe_pkg::COEFF_W-1:0]    coeff_value;
  logic [phe_pkg::KEY_W-1:0]      key;

  modport source (output valid, action, hash_index, term_index, coeff_value, key,
                  input ready);
  modport sink   (input valid, action, hash_index, term_index, coeff_value, key,
                  output ready);
endinterface

interface phe_out_if;
  logic                           valid;
  logic                           ready;
  logic [phe_pkg::RANGE_W-1:0]    hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface
`default_nettype wire

// File: design/polynomial_hash_eval_top.sv
`default_nettype none
// Coefficient write: accepted while idle, ready stays high, no result.
// Evaluate: the range scan finds ob = floor(log2(range)), then D Horner steps, D the
//   saturated degree, each with three 32x32 partial products on the one multiplier,
//   then the 64-step bit-serial remainder.
// Bad hash or range below 2: zero result. One item in work at a time.
// Reset (synchronous, active low) restores control and the config registers, not the memory.
module polynomial_hash_eval_top #(
  parameter int NUM_HASH_FUNCS = phe_pkg::DEF_NUM_HASH_FUNCS,
  parameter int MAX_DEGREE     = phe_pkg::DEF_MAX_DEGREE
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  phe_in_if.sink                           in_ch,
  phe_out_if.source                        out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [phe_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [phe_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [phe_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  localparam int TERMS = MAX_DEGREE + 1;
  localparam int DEPTH = NUM_HASH_FUNCS * TERMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int CW    = phe_pkg::COEFF_W;
  localparam int MW    = phe_pkg::MUL_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [phe_pkg::KB_W-1:0]    kb_r;
  logic [phe_pkg::RANGE_W-1:0] range_r;
  logic [phe_pkg::DEG_W-1:0]   deg_r;
  logic                        cfg_wr;
  phe_pkg::reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // registers sit on 8-byte strides; low address bits are ignored
  assign cfg_idx    = phe_pkg::reg_idx_t'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_r    <= phe_pkg::KEY_BITS_RST;
      range_r <= phe_pkg::HASH_RANGE_RST;
      deg_r   <= phe_pkg::POLY_DEGREE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        phe_pkg::REG_KEY_BITS:    kb_r    <= cfg_pwdata[phe_pkg::KB_W-1:0];
        phe_pkg::REG_HASH_RANGE:  range_r <= cfg_pwdata[phe_pkg::RANGE_W-1:0];
        phe_pkg::REG_POLY_DEGREE: deg_r   <= cfg_pwdata[phe_pkg::DEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      phe_pkg::REG_KEY_BITS:
        cfg_prdata = {{(phe_pkg::CFG_DW-phe_pkg::KB_W){1'b0}}, kb_r};
      phe_pkg::REG_HASH_RANGE:
        cfg_prdata = {{(phe_pkg::CFG_DW-phe_pkg::RANGE_W){1'b0}}, range_r};
      phe_pkg::REG_POLY_DEGREE:
        cfg_prdata = {{(phe_pkg::CFG_DW-phe_pkg::DEG_W){1'b0}}, deg_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  phe_pkg::state_t state_r, state_nxt;
  logic            in_ready;
  logic            in_fire;
  logic            h_ok;
  logic            t_ok;
  logic [AW-1:0]   in_base;
  logic [AW-1:0]   in_waddr;
  logic [DW-1:0]   deg_sat;

  assign in_ready = (state_r == phe_pkg::S_IDLE);
  assign in_fire  = in_ch.valid && in_ready;
  assign h_ok     = 32'(in_ch.hash_index) < NUM_HASH_FUNCS;
  assign t_ok     = 32'(in_ch.term_index) <= MAX_DEGREE;
  assign in_base  = AW'(32'(in_ch.hash_index) * TERMS);
  assign in_waddr = AW'(32'(in_ch.hash_index) * TERMS + 32'(in_ch.term_index));
  // degree above the table's depth saturates
  assign deg_sat  = (32'(deg_r) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(deg_r);

  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------------------
  // Coefficient memory: one write port from the input, one registered read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] coeff_mem [DEPTH];
  logic [CW-1:0] rdata_r;
  logic [AW-1:0] raddr;

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.action == phe_pkg::ACT_WRITE && h_ok && t_ok) begin
      coeff_mem[in_waddr] <= in_ch.coeff_value;
    end
    rdata_r <= coeff_mem[raddr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath
  // ---------------------------------------------------------------------------
  logic [AW-1:0]               base_r, base_nxt;
  logic [phe_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [DW-1:0]               d_r, d_nxt;
  logic [CW-1:0]               acc_r, acc_nxt;
  logic [CW-1:0]               sum_r, sum_nxt;
  logic [CW-1:0]               pacc_r, pacc_nxt;
  logic [phe_pkg::RANGE_W-1:0] scan_r, scan_nxt;
  logic [phe_pkg::KB_W-1:0]    ob_r, ob_nxt;
  logic [phe_pkg::RANGE_W-1:0] res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [phe_pkg::RANGE_W-1:0] out_data_r;
  logic                        out_load;

  logic                        mul_en;
  logic [MW-1:0]               mul_a;
  logic [MW-1:0]               mul_b;
  logic [2*MW-1:0]             prod_r;
  logic [CW-1:0]               prod_hi;
  phe_pkg::mod_req_t           mod_req;
  phe_pkg::mod_rsp_t           mod_rsp;

  logic [CW-1:0]               kmask;
  logic [CW-1:0]               acc_shr;

  // products are kept modulo 2^key_bits
  assign kmask   = ~({CW{1'b1}} << kb_r);
  // keep the top floor(log2(range)) bits of the key_bits-wide value
  assign acc_shr = (kb_r > ob_r) ? (acc_r >> (kb_r - ob_r)) : acc_r;
  // cross product lands at bit 32; only the low 63 bits survive
  assign prod_hi = {prod_r[CW-MW-1:0], {MW{1'b0}}};

  // coefficient d during a Horner step, constant term otherwise
  assign raddr = (state_r == phe_pkg::S_RD) ? (base_r + AW'(d_r)) : base_r;

  always_comb begin
    state_nxt        = state_r;
    base_nxt         = base_r;
    key_nxt          = key_r;
    d_nxt            = d_r;
    acc_nxt          = acc_r;
    sum_nxt          = sum_r;
    pacc_nxt         = pacc_r;
    scan_nxt         = scan_r;
    ob_nxt           = ob_r;
    res_nxt          = res_r;
    out_load         = 1'b0;
    mul_en           = 1'b0;
    mul_a            = sum_r[MW-1:0];
    mul_b            = key_r[MW-1:0];
    mod_req.start    = 1'b0;
    mod_req.dividend = {1'b0, acc_r} + {1'b0, rdata_r};
    mod_req.divisor  = range_r;

    unique case (state_r)
      phe_pkg::S_IDLE: begin
        if (in_fire && in_ch.action == phe_pkg::ACT_EVAL) begin
          base_nxt = in_base;
          key_nxt  = in_ch.key;
          d_nxt    = deg_sat;
          acc_nxt  = '0;
          scan_nxt = range_r;
          ob_nxt   = '0;
          // bad hash or a range of zero or one: result is zero
          if (!h_ok || range_r[phe_pkg::RANGE_W-1:1] == '0) begin
            res_nxt   = '0;
            state_nxt = phe_pkg::S_DONE;
          end else begin
            state_nxt = phe_pkg::S_LOG;
          end
        end
      end
      phe_pkg::S_LOG: begin
        // find floor(log2(range)), one bit a cycle
        if (scan_r[phe_pkg::RANGE_W-1:1] != '0) begin
          scan_nxt = scan_r >> 1;
          ob_nxt   = ob_r + phe_pkg::KB_W'(1);
        end else if (d_r != '0) begin
          state_nxt = phe_pkg::S_RD;
        end else begin
          state_nxt = phe_pkg::S_SHIFT;
        end
      end
      phe_pkg::S_RD: begin
        state_nxt = phe_pkg::S_ADD;
      end
      phe_pkg::S_ADD: begin
        sum_nxt   = acc_r + rdata_r;
        state_nxt = phe_pkg::S_M0;
      end
      phe_pkg::S_M0: begin
        mul_en    = 1'b1;
        state_nxt = phe_pkg::S_M1;
      end
      phe_pkg::S_M1: begin
        mul_en    = 1'b1;
        mul_a     = {1'b0, sum_r[CW-1:MW]};
        pacc_nxt  = prod_r[CW-1:0];
        state_nxt = phe_pkg::S_M2;
      end
      phe_pkg::S_M2: begin
        mul_en    = 1'b1;
        mul_b     = {1'b0, key_r[phe_pkg::KEY_W-1:MW]};
        pacc_nxt  = pacc_r + prod_hi;
        state_nxt = phe_pkg::S_M3;
      end
      phe_pkg::S_M3: begin
        acc_nxt   = (pacc_r + prod_hi) & kmask;
        d_nxt     = d_r - DW'(1);
        state_nxt = (d_r == DW'(1)) ? phe_pkg::S_SHIFT : phe_pkg::S_RD;
      end
      phe_pkg::S_SHIFT: begin
        acc_nxt   = acc_shr;
        state_nxt = phe_pkg::S_ADDC;
      end
      phe_pkg::S_ADDC: begin
        mod_req.start = 1'b1;
        state_nxt     = phe_pkg::S_MOD;
      end
      phe_pkg::S_MOD: begin
        if (mod_rsp.done) begin
          res_nxt   = mod_rsp.rem;
          state_nxt = phe_pkg::S_DONE;
        end
      end
      phe_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = phe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = phe_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phe_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    key_r  <= key_nxt;
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    pacc_r <= pacc_nxt;
    scan_r <= scan_nxt;
    ob_r   <= ob_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_data_r;

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  phe_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  phe_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

endmodule
`default_nettype wire

// File: design/phe_mul.sv
`default_nettype none
module phe_mul (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [phe_pkg::MUL_W-1:0]      a,
  input  wire logic [phe_pkg::MUL_W-1:0]      b,
  output logic      [2*phe_pkg::MUL_W-1:0]    prod_r
);

  // one partial product per cycle while en is high, registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule
`default_nettype wire

// File: design/phe_mod.sv
`default_nettype none
module phe_mod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire phe_pkg::mod_req_t req,
  output phe_pkg::mod_rsp_t      rsp
);

  localparam int CNT_W = $clog2(phe_pkg::DIVD_W + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [phe_pkg::DIVD_W-1:0]    num_r, num_nxt;
  logic [phe_pkg::RANGE_W-1:0]   rem_r, rem_nxt;
  logic [phe_pkg::RANGE_W-1:0]   div_r, div_nxt;
  logic [phe_pkg::DIVD_W-1:0]    trial;
  logic [phe_pkg::DIVD_W-1:0]    diff;

  // restoring remainder, one dividend bit per cycle while busy
  assign trial = {rem_r, num_r[phe_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(phe_pkg::DIVD_W);
      num_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[phe_pkg::DIVD_W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[phe_pkg::RANGE_W-1:0]
                                         : trial[phe_pkg::RANGE_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// File: design/phe_checker.sv
`default_nettype none
module phe_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_action,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [phe_pkg::RANGE_W-1:0] out_hash_value
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // an evaluate beat occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == phe_pkg::ACT_EVAL) |=> !in_ready)
    else $error("ready after evaluate beat");

  // a coefficient write never blocks the input
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == phe_pkg::ACT_WRITE) |=> in_ready)
    else $error("ready dropped after write beat");

  // results only appear at the end of an evaluation
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without evaluation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hash_value)))
    else $error("stalled result changed");

endmodule

bind polynomial_hash_eval_top phe_checker u_phe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_action      (in_ch.action),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hash_value (out_ch.hash_value)
);
`default_nettype wire
